// File: hw/rtl/bvc_pkg.sv
// Shared types and constants of the bounding-volume cull classifier.
`timescale 1ns / 1ps
`default_nettype none
package bvc_pkg;

  localparam int CoordW  = 24;
  localparam int LenW    = 23;
  localparam int MagW    = CoordW + 1;
  localparam int SqW     = 2 * CoordW + 1;
  localparam int D2W     = SqW + 2;
  localparam int RsumW   = LenW + 1;
  localparam int Rsum2W  = 2 * RsumW;
  localparam int Rdiff2W = 2 * LenW;
  localparam int CfgIdxW = 3;
  localparam int InDataW = 168;
  localparam int OutDataW = 8;

  typedef enum logic [1:0] {
    CLS_REJECT = 2'd0,
    CLS_ACCEPT = 2'd1,
    CLS_SPLIT  = 2'd2
  } cls_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_QCX  = 3'd0,
    REG_QCY  = 3'd1,
    REG_QCZ  = 3'd2,
    REG_QRAD = 3'd3,
    REG_QHX  = 3'd4,
    REG_QHY  = 3'd5,
    REG_QHZ  = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic signed [CoordW-1:0] cx;
    logic signed [CoordW-1:0] cy;
    logic signed [CoordW-1:0] cz;
    logic [LenW-1:0]          rad;
    logic [LenW-1:0]          hx;
    logic [LenW-1:0]          hy;
    logic [LenW-1:0]          hz;
  } query_t;

  typedef struct packed {
    logic                is_part;
    logic                part_sel;
    logic [SqW-1:0]      sq_x;
    logic [SqW-1:0]      sq_y;
    logic [SqW-1:0]      sq_z;
    logic [Rsum2W-1:0]   rsum2;
    logic                rin_ok;
    logic [Rdiff2W-1:0]  rdiff2;
    logic                box_in;
  } geom_t;

endpackage
`default_nettype wire

// File: hw/rtl/bvc_cfg_regs.sv
// Query bound configuration registers.
`timescale 1ns / 1ps
`default_nettype none
module bvc_cfg_regs
  import bvc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [CfgIdxW-1:0] cfg_index,
  input  wire logic [31:0]        cfg_data,
  output query_t                  query
);

  query_t q_r;
  query_t q_nxt;

  assign cfg_ready = 1'b1;
  assign query     = q_r;

  always_comb begin
    q_nxt = q_r;
    if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_QCX:  q_nxt.cx  = cfg_data[CoordW-1:0];
        REG_QCY:  q_nxt.cy  = cfg_data[CoordW-1:0];
        REG_QCZ:  q_nxt.cz  = cfg_data[CoordW-1:0];
        REG_QRAD: q_nxt.rad = cfg_data[LenW-1:0];
        REG_QHX:  q_nxt.hx  = cfg_data[LenW-1:0];
        REG_QHY:  q_nxt.hy  = cfg_data[LenW-1:0];
        REG_QHZ:  q_nxt.hz  = cfg_data[LenW-1:0];
        default:  q_nxt = q_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= '0;
    end else begin
      q_r <= q_nxt;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/bvc_geom.sv
// Input register and first stage: center distances, squares and box test.
`timescale 1ns / 1ps
`default_nettype none
module bvc_geom
  import bvc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire logic [InDataW-1:0] in_tdata,
  input  wire logic               in_tuser,
  input  query_t                  query,
  output logic                    geo_valid,
  input  wire logic               geo_ready,
  output geom_t                   geo
);

  logic                     v0_r;
  logic                     is_part_r;
  logic [InDataW-1:0]       data_r;
  logic                     v1_r;
  geom_t                    geo_r;
  geom_t                    geo_nxt;
  logic                     adv1;
  logic                     ready0;
  logic signed [CoordW-1:0] cx, cy, cz;
  logic [LenW-1:0]          rad, hx, hy, hz;
  logic signed [MagW-1:0]   dx, dy, dz;
  logic [MagW-1:0]          ax, ay, az;
  logic [2*MagW-1:0]        px, py, pz;
  logic [RsumW-1:0]         rsum;
  logic [LenW-1:0]          rdiff;

  assign adv1      = !v1_r || geo_ready;
  assign ready0    = !v0_r || adv1;
  assign in_tready = ready0;
  assign geo_valid = v1_r;
  assign geo       = geo_r;

  assign cx  = data_r[23:0];
  assign cy  = data_r[47:24];
  assign cz  = data_r[71:48];
  assign rad = data_r[94:72];
  assign hx  = data_r[117:95];
  assign hy  = data_r[140:118];
  assign hz  = data_r[163:141];

  always_comb begin
    dx = {query.cx[CoordW-1], query.cx} - {cx[CoordW-1], cx};
    dy = {query.cy[CoordW-1], query.cy} - {cy[CoordW-1], cy};
    dz = {query.cz[CoordW-1], query.cz} - {cz[CoordW-1], cz};
    ax = dx[MagW-1] ? MagW'(-dx) : MagW'(dx);
    ay = dy[MagW-1] ? MagW'(-dy) : MagW'(dy);
    az = dz[MagW-1] ? MagW'(-dz) : MagW'(dz);
    px = ax * ax;
    py = ay * ay;
    pz = az * az;
    rsum  = {1'b0, query.rad} + {1'b0, rad};
    rdiff = query.rad - rad;

    geo_nxt.is_part  = is_part_r;
    geo_nxt.part_sel = data_r[164];
    geo_nxt.sq_x     = px[SqW-1:0];
    geo_nxt.sq_y     = py[SqW-1:0];
    geo_nxt.sq_z     = pz[SqW-1:0];
    geo_nxt.rsum2    = rsum * rsum;
    geo_nxt.rin_ok   = query.rad > rad;
    geo_nxt.rdiff2   = rdiff * rdiff;
    geo_nxt.box_in   = (({1'b0, ax} + {3'b000, hx}) < {3'b000, query.hx}) &&
                       (({1'b0, ay} + {3'b000, hy}) < {3'b000, query.hy}) &&
                       (({1'b0, az} + {3'b000, hz}) < {3'b000, query.hz});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
    end else begin
      if (ready0) begin
        v0_r <= in_tvalid;
      end
      if (adv1) begin
        v1_r <= v0_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready0 && in_tvalid) begin
      data_r    <= in_tdata;
      is_part_r <= in_tuser;
    end
    if (adv1 && v0_r) begin
      geo_r <= geo_nxt;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/bvc_classify.sv
// Second stage: distance sum, sphere and box decisions, class state, result register.
`timescale 1ns / 1ps
`default_nettype none
module bvc_classify
  import bvc_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                geo_valid,
  output logic                     geo_ready,
  input  geom_t                    geo,
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  output logic [OutDataW-1:0]      out_tdata
);

  logic           vo_r;
  cls_t           cls_r;
  cls_t           cls_nxt;
  cls_t           obj_cls;
  logic [1:0]     code_r;
  logic [1:0]     code_nxt;
  logic           keep_r;
  logic           keep_nxt;
  logic [D2W-1:0] d2;
  logic           apart;
  logic           overlap;
  logic           take;

  assign geo_ready  = !vo_r || out_tready;
  assign take       = geo_ready && geo_valid;
  assign out_tvalid = vo_r;
  assign out_tdata  = {{(OutDataW-3){1'b0}}, keep_r, code_r};

  always_comb begin
    d2 = {2'b00, geo.sq_x} + {2'b00, geo.sq_y} + {2'b00, geo.sq_z};
    apart   = d2 > {{(D2W-Rsum2W){1'b0}}, geo.rsum2};
    overlap = d2 < {{(D2W-Rsum2W){1'b0}}, geo.rsum2};

    priority if (apart) begin
      obj_cls = CLS_REJECT;
    end else if (geo.rin_ok && (d2 < {{(D2W-Rdiff2W){1'b0}}, geo.rdiff2})) begin
      obj_cls = CLS_ACCEPT;
    end else if (geo.box_in) begin
      obj_cls = CLS_ACCEPT;
    end else begin
      obj_cls = CLS_SPLIT;
    end

    if (geo.is_part) begin
      cls_nxt  = cls_r;
      code_nxt = cls_r;
      // Under split, a selected part outside the query sphere is dropped.
      keep_nxt = geo.part_sel && !((cls_r == CLS_SPLIT) && !overlap);
    end else begin
      cls_nxt  = obj_cls;
      code_nxt = obj_cls;
      keep_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r  <= 1'b0;
      cls_r <= CLS_ACCEPT;
    end else begin
      if (geo_ready) begin
        vo_r <= geo_valid;
      end
      if (take) begin
        cls_r <= cls_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      code_r <= code_nxt;
      keep_r <= keep_nxt;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/bounding_volume_cull_classifier_core.sv
// Top level of the bounding-volume cull classifier.
//
//   channel | direction | beat contents
//   in_     | slave     | tuser: req_type; tdata: centers, radius, half extents, part_selected
//   out_    | master    | tdata: class_code, part_keep
//   cfg_    | write     | cfg_index selects a query register, cfg_data holds its value
//
// One beat in per cycle while in_tready is high; every beat gives exactly one result beat
// through the three pipeline registers (input register, square stage, result register).
// Reset clears the query registers to zero and the object class to accept.
// A stall on out_tready fills the empty stages first, then holds in_tready low.
// Configuration is taken at any time and expected only while the pipeline is empty.
`timescale 1ns / 1ps
`default_nettype none
module bounding_volume_cull_classifier_core
  import bvc_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  // tdata from bit 0: center_x[23:0], center_y[47:24], center_z[71:48], radius[94:72],
  // half_x[117:95], half_y[140:118], half_z[163:141], part_selected[164], zero pad
  input  wire logic [InDataW-1:0]  in_tdata,
  // tuser: req_type
  input  wire logic                in_tuser,
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  // tdata from bit 0: class_code[1:0], part_keep[2], zero pad
  output logic [OutDataW-1:0]      out_tdata,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [31:0]         cfg_data
);

  query_t query;
  geom_t  geo;
  logic   geo_valid;
  logic   geo_ready;

  bvc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .query     (query)
  );

  bvc_geom u_geom (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .query     (query),
    .geo_valid (geo_valid),
    .geo_ready (geo_ready),
    .geo       (geo)
  );

  bvc_classify u_cls (
    .clk        (clk),
    .rst_n      (rst_n),
    .geo_valid  (geo_valid),
    .geo_ready  (geo_ready),
    .geo        (geo),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
`default_nettype wire
